### rtl/eg3_pkg.sv
// Shared types and constants of the east gradient 3x3 filter.
`timescale 1ns / 1ps

package eg3_pkg;

	// Fixed field widths.
	localparam int PIX_W = 8;
	localparam int IDX_W = 24;
	localparam int CFG_W = 14;

	// Row stride after reset, before saturation.
	localparam int CFG_RESET = 3072;

	// Input beat: one image byte and its frame marker.
	typedef struct packed {
		logic [PIX_W-1:0] pixel_byte;
		logic             frame_start;
	} in_beat_t;

	// Output beat: filter result and the position of its centre byte.
	typedef struct packed {
		logic [PIX_W-1:0] filtered_byte;
		logic [IDX_W-1:0] center_index;
	} out_beat_t;

endpackage

### rtl/eg3_stream_if.sv
// Valid/ready stream interface carrying one payload beat.
`timescale 1ns / 1ps

interface eg3_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### rtl/eg3_line_buf.sv
// Circular byte delay line with one write port and two registered read ports.
`timescale 1ns / 1ps

module eg3_line_buf #(
	parameter int DEPTH    = 16392,
	parameter int STRIDE_W = 14,
	parameter int BACK_W   = 3
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  logic [eg3_pkg::PIX_W-1:0] wr_data,
	input  logic                      rd_en,
	input  logic [BACK_W-1:0]         rd_back,
	input  logic [STRIDE_W-1:0]       stride,
	output logic [eg3_pkg::PIX_W-1:0] rd_one,
	output logic [eg3_pkg::PIX_W-1:0] rd_two
);
	import eg3_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam logic [AW:0] DEPTH_X = (AW+1)'(DEPTH);

	logic [PIX_W-1:0] mem [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW:0]      raw_one;
	logic [AW:0]      raw_two;
	logic [AW:0]      fix_one;
	logic [AW:0]      fix_two;
	logic [AW:0]      stride_x;
	logic [AW:0]      back_x;

	// Read addresses one and two strides behind the write pointer, plus the
	// extra offset. The sum stays below twice the depth, so one subtract wraps it.
	always_comb begin
		stride_x = (AW+1)'(stride);
		back_x   = (AW+1)'(rd_back);
		raw_one  = {1'b0, wr_ptr_q} + DEPTH_X - back_x - stride_x;
		raw_two  = {1'b0, wr_ptr_q} + DEPTH_X - back_x - (stride_x << 1);
		fix_one  = (raw_one >= DEPTH_X) ? raw_one - DEPTH_X : raw_one;
		fix_two  = (raw_two >= DEPTH_X) ? raw_two - DEPTH_X : raw_two;
	end

	// Write pointer advances once per pushed beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
		end else if (push) begin
			if (wr_ptr_q == AW'(DEPTH - 1)) begin
				wr_ptr_q <= '0;
			end else begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
		end
	end

	// Memory array with registered reads.
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_data;
		end
		if (rd_en) begin
			rd_one <= mem[fix_one[AW-1:0]];
			rd_two <= mem[fix_two[AW-1:0]];
		end
	end

endmodule

### rtl/east_gradient_3x3_filter_top.sv
// Top level of the east compass gradient 3x3 filter over an RGB byte stream.
//
//   channel   dir  handshake      payload
//   pixels    in   valid/ready    pixel_byte, frame_start
//   results   out  valid/ready    filtered_byte, center_index
//   cfg       in   cfg_we         cfg_wdata (row stride in bytes)
//
// One byte is accepted per clock unless a tap reload or a result stall holds
// it off; a result passes the delay line read register and the result register.
// The delay line memory has one write and two read ports, which sets the rate.
// After reset or a stride write the horizontal taps of the upper rows are
// reloaded from the delay line, with pixels held off.
// A stall on results holds the result register; pixels keep flowing while it
// or the stage in front of it has room.
`timescale 1ns / 1ps

module east_gradient_3x3_filter_top #(
	parameter int MAX_ROW_BYTES = 8192,
	parameter int PIXEL_STRIDE  = 3
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [eg3_pkg::CFG_W-1:0] cfg_wdata,
	eg3_stream_if.sink                pixels,
	eg3_stream_if.source              results
);
	import eg3_pkg::*;

	localparam int DEPTH    = 2 * MAX_ROW_BYTES + 2 * PIXEL_STRIDE + 2;
	localparam int TAPS     = 2 * PIXEL_STRIDE;
	localparam int STRIDE_W = $clog2(MAX_ROW_BYTES + 1);
	localparam int BACK_W   = $clog2(TAPS + 1);
	localparam int RST_STRIDE = (CFG_RESET < TAPS) ? TAPS :
		((CFG_RESET > MAX_ROW_BYTES) ? MAX_ROW_BYTES : CFG_RESET);

	logic [STRIDE_W-1:0] stride_q;
	logic [BACK_W-1:0]   refill_q;
	logic [IDX_W-1:0]    pos_q;
	logic [IDX_W-1:0]    pos_next;
	logic [31:0]         wdata_x;
	logic [31:0]         wdata_sat;

	logic                accept;
	logic                adv_s1;
	logic                hit_s1;
	logic                v_s1;
	logic                f_s1;
	logic [PIX_W-1:0]    byte_s1;
	logic [IDX_W-1:0]    n_s1;
	logic [PIX_W-1:0]    row1_cur;
	logic [PIX_W-1:0]    row2_cur;

	logic [PIX_W-1:0]    sr0_q [TAPS];
	logic [PIX_W-1:0]    sr1_q [TAPS];
	logic [PIX_W-1:0]    sr2_q [TAPS];

	logic                v_s2;
	out_beat_t           out_s2;

	logic                rd_en;
	logic [BACK_W-1:0]   rd_back;
	logic signed [11:0]  sum;
	logic [PIX_W-1:0]    clamped;
	logic [IDX_W:0]      thresh;
	logic [IDX_W-1:0]    center;

	// Handshake: stage one moves on when the result register is free or drained.
	assign adv_s1       = v_s1 && (!v_s2 || results.ready);
	assign pixels.ready = (refill_q == '0) && (!v_s1 || !v_s2 || results.ready);
	assign accept       = pixels.valid && pixels.ready;

	// Saturate the written stride into its legal range.
	always_comb begin
		wdata_x = 32'(cfg_wdata);
		if (wdata_x < 32'(TAPS)) begin
			wdata_sat = 32'(TAPS);
		end else if (wdata_x > 32'(MAX_ROW_BYTES)) begin
			wdata_sat = 32'(MAX_ROW_BYTES);
		end else begin
			wdata_sat = wdata_x;
		end
	end

	// Stride register and the tap reload counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= STRIDE_W'(RST_STRIDE);
			refill_q <= BACK_W'(TAPS);
		end else if (cfg_we) begin
			stride_q <= STRIDE_W'(wdata_sat);
			refill_q <= BACK_W'(TAPS);
		end else if (refill_q != '0) begin
			refill_q <= refill_q - BACK_W'(1);
		end
	end

	// Delay line reads: a beat reads its own upper-row taps; a reload step
	// reads older bytes, oldest first.
	assign rd_en   = accept || (refill_q != '0);
	assign rd_back = accept ? '0 : refill_q;

	eg3_line_buf #(
		.DEPTH    (DEPTH),
		.STRIDE_W (STRIDE_W),
		.BACK_W   (BACK_W)
	) u_line_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (accept),
		.wr_data (pixels.data.pixel_byte),
		.rd_en   (rd_en),
		.rd_back (rd_back),
		.stride  (stride_q),
		.rd_one  (row1_cur),
		.rd_two  (row2_cur)
	);

	// Position of the incoming byte within its frame.
	assign pos_next = pixels.data.frame_start ? '0 : pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			v_s1  <= 1'b0;
			f_s1  <= 1'b0;
		end else begin
			f_s1 <= !accept && (refill_q != '0) && !cfg_we;
			if (accept) begin
				pos_q <= pos_next + IDX_W'(1);
				v_s1  <= 1'b1;
			end else if (adv_s1) begin
				v_s1  <= 1'b0;
			end
		end
	end

	// Stage one payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= pixels.data.pixel_byte;
			n_s1    <= pos_next;
		end
	end

	// Horizontal tap shift registers, newest at index zero.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			sr0_q[0] <= byte_s1;
			for (int i = 1; i < TAPS; i++) begin
				sr0_q[i] <= sr0_q[i-1];
			end
		end
		if (adv_s1 || f_s1) begin
			sr1_q[0] <= row1_cur;
			sr2_q[0] <= row2_cur;
			for (int i = 1; i < TAPS; i++) begin
				sr1_q[i] <= sr1_q[i-1];
				sr2_q[i] <= sr2_q[i-1];
			end
		end
	end

	// Kernel sum: -1 1 1 / -1 -2 1 / -1 1 1, oldest column on the left.
	always_comb begin
		sum = - $signed({4'b0, sr2_q[TAPS-1]}) + $signed({4'b0, sr2_q[PIXEL_STRIDE-1]})
			+ $signed({4'b0, row2_cur})
			- $signed({4'b0, sr1_q[TAPS-1]}) - $signed({3'b0, sr1_q[PIXEL_STRIDE-1], 1'b0})
			+ $signed({4'b0, row1_cur})
			- $signed({4'b0, sr0_q[TAPS-1]}) + $signed({4'b0, sr0_q[PIXEL_STRIDE-1]})
			+ $signed({4'b0, byte_s1});
		if (sum < 0) begin
			clamped = '0;
		end else if (sum > 12'sd255) begin
			clamped = '1;
		end else begin
			clamped = sum[PIX_W-1:0];
		end
	end

	// A result exists once two rows and two pixels of the frame are in.
	always_comb begin
		thresh = ((IDX_W+1)'(stride_q) << 1) + (IDX_W+1)'(TAPS);
		hit_s1 = {1'b0, n_s1} >= thresh;
		center = n_s1 - IDX_W'(stride_q) - IDX_W'(PIXEL_STRIDE);
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s1) begin
			v_s2 <= hit_s1;
		end else if (results.ready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && hit_s1) begin
			out_s2.filtered_byte <= clamped;
			out_s2.center_index  <= center;
		end
	end

	assign results.valid = v_s2;
	assign results.data  = out_s2;

endmodule

### dv/east_gradient_3x3_filter_top_tb.sv
// Self-checking testbench for the east gradient 3x3 filter top level.
`timescale 1ns / 1ps

module east_gradient_3x3_filter_top_tb;
	import eg3_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int MAX_ROW       = 8192;
	localparam int PIX_STEP      = 3;
	localparam int LINE_DEPTH    = 2 * MAX_ROW + 2 * PIX_STEP + 2;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS  = 1850;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	eg3_stream_if #(.T(in_beat_t))  pix_if ();
	eg3_stream_if #(.T(out_beat_t)) res_if ();

	east_gradient_3x3_filter_top #(
		.MAX_ROW_BYTES (MAX_ROW),
		.PIXEL_STRIDE  (PIX_STEP)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pixels    (pix_if),
		.results   (res_if)
	);

	// Predictor state: the byte history, the frame position and the stride.
	logic [PIX_W-1:0] line_bytes [LINE_DEPTH];
	logic [IDX_W-1:0] next_position;
	int unsigned      write_slot;
	logic [CFG_W-1:0] row_stride;
	out_beat_t        pending_results [$];
	out_beat_t        oldest_result;

	int error_count;
	int burst_left;
	int items_sent;

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Stride actually used by the kernel, saturated to its legal span.
	function automatic int unsigned active_stride();
		int unsigned s;
		s = row_stride;
		if (s < 2 * PIX_STEP) begin
			s = 2 * PIX_STEP;
		end
		if (s > MAX_ROW) begin
			s = MAX_ROW;
		end
		return s;
	endfunction

	// Byte that arrived the given number of beats back.
	function automatic int line_tap(int unsigned back);
		return int'(line_bytes[(write_slot + LINE_DEPTH - back) % LINE_DEPTH]);
	endfunction

	function automatic void clear_history();
		for (int i = 0; i < LINE_DEPTH; i++) begin
			line_bytes[i] = '0;
		end
		next_position = '0;
		write_slot    = 0;
		row_stride    = CFG_W'(CFG_RESET);
	endfunction

	// Work out the gradient result, if any, that an accepted byte causes.
	function automatic void gradient_predict(in_beat_t beat);
		int unsigned s;
		int unsigned n;
		int          sum;
		out_beat_t   res;
		s = active_stride();
		if (beat.frame_start) begin
			next_position = '0;
		end
		n = next_position;
		line_bytes[write_slot] = beat.pixel_byte;
		if (n >= 2 * s + 2 * PIX_STEP) begin
			sum = -line_tap(2 * s + 2 * PIX_STEP) + line_tap(2 * s + PIX_STEP)
				+ line_tap(2 * s)
				- line_tap(s + 2 * PIX_STEP) - 2 * line_tap(s + PIX_STEP) + line_tap(s)
				- line_tap(2 * PIX_STEP) + line_tap(PIX_STEP) + line_tap(0);
			if (sum > 255) begin
				sum = 255;
			end
			if (sum < 0) begin
				sum = 0;
			end
			res.filtered_byte = PIX_W'(sum);
			res.center_index  = IDX_W'(n - s - PIX_STEP);
			pending_results.push_back(res);
		end
		next_position = next_position + 1'b1;
		write_slot    = (write_slot + 1) % LINE_DEPTH;
	endfunction

	// Predict on every accepted pixel beat and check every accepted result beat.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pix_if.valid && pix_if.ready) begin
				gradient_predict(pix_if.data);
			end
			if (res_if.valid && res_if.ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result: filtered_byte %0d center_index %0d",
						$time, res_if.data.filtered_byte, res_if.data.center_index);
					error_count++;
				end else begin
					oldest_result = pending_results.pop_front();
					if (res_if.data.filtered_byte !== oldest_result.filtered_byte) begin
						$display("%0t: filtered_byte mismatch: expected %0d, actual %0d",
							$time, oldest_result.filtered_byte, res_if.data.filtered_byte);
						error_count++;
					end
					if (res_if.data.center_index !== oldest_result.center_index) begin
						$display("%0t: center_index mismatch: expected %0d, actual %0d",
							$time, oldest_result.center_index, res_if.data.center_index);
						error_count++;
					end
				end
			end
		end
	end

	// The result side stalls in randomly chosen modes, each held for a random run.
	initial begin : result_stalls
		int mode;
		int left;
		mode = 0;
		left = 0;
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(16, 200);
			end
			left--;
			case (mode)
				0: begin
					res_if.ready <= 1'b1;
				end
				1: begin
					res_if.ready <= 1'($urandom_range(0, 1));
				end
				2: begin
					res_if.ready <= ($urandom_range(0, 7) != 0);
				end
				default: begin
					res_if.ready <= ($urandom_range(0, 9) == 0);
				end
			endcase
		end
	end

	// Send one pixel beat; the sender works in bursts with random gaps between.
	task automatic send_byte(input logic [PIX_W-1:0] value, input logic first);
		in_beat_t beat;
		int       gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			case ($urandom_range(0, 5))
				0, 1: gap = 0;
				2: gap = $urandom_range(10, 20);
				default: gap = $urandom_range(1, 6);
			endcase
			if (gap > 0) begin
				pix_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		beat.pixel_byte  = value;
		beat.frame_start = first;
		pix_if.valid <= 1'b1;
		pix_if.data  <= beat;
		@(posedge clk);
		while (!pix_if.ready) begin
			@(posedge clk);
		end
		items_sent++;
	endtask

	// Send a run of bytes; the first may open a frame, and noise may restart one.
	task automatic send_frame(input int len, input bit open_frame, input bit extremes,
		input bit noise);
		logic [PIX_W-1:0] value;
		logic             first;
		for (int i = 0; i < len; i++) begin
			if (extremes) begin
				value = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			end else begin
				value = PIX_W'($urandom_range(0, 255));
			end
			first = (i == 0 && open_frame) || (noise && $urandom_range(0, 199) == 0);
			send_byte(value, first);
		end
	endtask

	// Wait until every expected result has arrived and the pipeline has drained.
	task automatic wait_idle();
		pix_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_stride(input logic [CFG_W-1:0] value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we     <= 1'b0;
		row_stride  = value;
	endtask

	// The stride left by reset, one full frame plus a few results.
	task automatic test_reset_stride();
		send_frame(2 * CFG_RESET + 2 * PIX_STEP + 1 + 12, 1'b1, 1'b0, 1'b0);
	endtask

	// Strides below, at and just above the minimum, with saturated sums both ways.
	task automatic test_small_strides();
		send_frame(2 * 6 + 7 + 6, 1'b1, 1'b1, 1'b0);
		set_stride(CFG_W'(0));
		send_frame(2 * 6 + 7 + 6, 1'b1, 1'b1, 1'b0);
		set_stride(CFG_W'(5));
		send_frame(2 * 6 + 7 + 4, 1'b1, 1'b1, 1'b0);
		set_stride(CFG_W'(6));
		send_frame(2 * 6 + 7 + 8, 1'b1, 1'b0, 1'b0);
		set_stride(CFG_W'(7));
		send_frame(2 * 7 + 7 + 8, 1'b1, 1'b1, 1'b0);
	endtask

	// A frame restarted before it fills, and two frame starts in a row.
	task automatic test_frame_restart();
		set_stride(CFG_W'(10));
		send_frame(15, 1'b1, 1'b0, 1'b0);
		send_frame(1, 1'b1, 1'b0, 1'b0);
		send_frame(2 * 10 + 7 + 10, 1'b1, 1'b0, 1'b0);
	endtask

	// All ones in the register saturate to the largest stride; the history wraps.
	task automatic test_max_stride();
		set_stride(CFG_W'(16383));
		send_frame(2 * MAX_ROW + 2 * PIX_STEP + 1 + 24, 1'b1, 1'b0, 1'b0);
	endtask

	// The stride changes inside a frame, which then goes on without a new start.
	task automatic test_mid_frame_stride();
		set_stride(CFG_W'(20));
		send_frame(80, 1'b1, 1'b0, 1'b0);
		set_stride(CFG_W'(12));
		send_frame(60, 1'b0, 1'b0, 1'b0);
		set_stride(CFG_W'(30));
		send_frame(40, 1'b0, 1'b1, 1'b0);
	endtask

	// Random strides and frames: mostly well-formed, some short, some unmarked.
	task automatic test_random();
		int unsigned s;
		int          frames;
		int          len;
		int          kind;
		bit          extremes;
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: s = $urandom_range(0, 5);
				1: s = $urandom_range(49, 160);
				default: s = $urandom_range(6, 48);
			endcase
			set_stride(CFG_W'(s));
			frames = $urandom_range(1, 3);
			for (int f = 0; f < frames; f++) begin
				s        = active_stride();
				kind     = $urandom_range(0, 9);
				extremes = ($urandom_range(0, 3) == 0);
				if (kind == 0) begin
					len = $urandom_range(1, 2 * s + 2 * PIX_STEP);
					send_frame(len, 1'b1, extremes, 1'b0);
				end else if (kind == 1) begin
					len = $urandom_range(10, 60);
					send_frame(len, 1'b0, extremes, 1'b0);
				end else begin
					len = 2 * s + 2 * PIX_STEP + 1 + $urandom_range(0, 80);
					send_frame(len, 1'b1, extremes, 1'b1);
				end
			end
		end
	endtask

	initial begin
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_wdata    <= '0;
		pix_if.valid <= 1'b0;
		pix_if.data  <= '0;
		error_count   = 0;
		burst_left    = 0;
		items_sent    = 0;
		clear_history();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_stride();
		test_small_strides();
		test_frame_restart();
		test_mid_frame_stride();
		test_max_stride();
		test_random();

		wait_idle();
		if (error_count == 0) begin
			$display("** east_gradient_3x3_filter_top: PASSED **");
		end else begin
			$display("** east_gradient_3x3_filter_top: FAILED **");
		end
		$finish;
	end

	// Hard limit on the run time in case the block hangs.
	initial begin
		#40_000_000;
		$display("** east_gradient_3x3_filter_top: FAILED **");
		$finish;
	end

endmodule

### sim.f
rtl/eg3_pkg.sv
rtl/eg3_stream_if.sv
rtl/eg3_line_buf.sv
rtl/east_gradient_3x3_filter_top.sv
dv/east_gradient_3x3_filter_top_tb.sv
